@@ rtl/button_press_classifier_top_macros.svh @@
// ----------------------------------------------------------------------------
// button press classifier assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication
`define BPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// shared widths, codes, reset values and payload types of the button classifier
// ----------------------------------------------------------------------------
package bpc_pkg;

    // widths
    localparam int TIME_WIDTH_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int PRESS_W        = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int EV_W           = 2;

    typedef logic [CFG_W-1:0]     t_cfg_val;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [EV_W-1:0]      t_event;
    typedef logic [PRESS_W-1:0]   t_press_time;

    // event codes
    localparam t_event EV_NONE  = 2'd0;
    localparam t_event EV_SHORT = 2'd1;
    localparam t_event EV_LONG  = 2'd2;

    // register indexes
    localparam t_cfg_idx REG_DEBOUNCE = 2'd0;
    localparam t_cfg_idx REG_HOLD     = 2'd1;
    localparam t_cfg_idx REG_STEP     = 2'd2;

    // register reset values
    localparam t_cfg_val DEBOUNCE_RST = 16'd50;
    localparam t_cfg_val HOLD_RST     = 16'd600;
    localparam t_cfg_val STEP_RST     = 16'd200;

    // one result item
    typedef struct packed {
        t_event      event_res;
        logic        pressed;
        t_press_time press_time;
        logic        step;
        logic        buzzer_on;
        logic        buzzer_off;
        logic        chirp;
    } t_out_item;

endpackage
`default_nettype wire

@@ rtl/bpc_channels.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc channel interfaces
// valid/ready channels for tick input, result output and register writes
// ----------------------------------------------------------------------------

// tick input channel
interface bpc_in_if;
    logic valid;
    logic ready;
    logic raw_level;

    modport source (output valid, output raw_level, input ready);
    modport sink   (input valid, input raw_level, output ready);
endinterface

// result output channel
interface bpc_out_if;
    logic                valid;
    logic                ready;
    bpc_pkg::t_event     event_res;
    logic                pressed;
    bpc_pkg::t_press_time press_time;
    logic                step;
    logic                buzzer_on;
    logic                buzzer_off;
    logic                chirp;

    modport source (output valid, output event_res, output pressed, output press_time,
                    output step, output buzzer_on, output buzzer_off, output chirp,
                    input ready);
    modport sink   (input valid, input event_res, input pressed, input press_time,
                    input step, input buzzer_on, input buzzer_off, input chirp,
                    output ready);
endinterface

// register write channel
interface bpc_cfg_if;
    logic              valid;
    logic              ready;
    bpc_pkg::t_cfg_idx index;
    bpc_pkg::t_cfg_val data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/button_press_classifier_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_press_classifier_top
// debounce, long press and auto-repeat for one push button, one item per tick
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one transaction per millisecond tick with the raw pin level
//   (0 = pressed). o_out returns exactly one result per tick: event code,
//   debounced state, press duration and the step / buzzer / chirp pulses.
//   i_cfg writes debounce_ms (0), hold_ms (1) and step_ms (2); other indexes
//   are dropped. write registers only while no tick is in flight.
// path: an accepted tick passes the input register, then the result register,
//   and its result is taken from the result register.
// throughput: one tick per cycle unless o_out stalls; the whole update of
//   counters and flags is one compare-and-increment pass between the two registers.
// reset: counters and flags clear, registers return to 50 / 600 / 200 ms,
//   both pipeline stages empty.
// stall: while o_out is held off the result register keeps its value, the
//   input register fills, then i_in.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`include "button_press_classifier_top_macros.svh"

module button_press_classifier_top #(
    parameter int TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpc_in_if.sink     i_in,
    bpc_out_if.source  o_out,
    bpc_cfg_if.sink    i_cfg
);

    localparam int CMP_W = (TIME_WIDTH > bpc_pkg::PRESS_W) ? TIME_WIDTH : bpc_pkg::PRESS_W;

    typedef logic [TIME_WIDTH-1:0] t_time;
    typedef logic [CMP_W-1:0]      t_cmp;

    // configuration registers
    bpc_pkg::t_cfg_val r_debounce_ms;
    bpc_pkg::t_cfg_val r_hold_ms;
    bpc_pkg::t_cfg_val r_step_ms;

    // input stage
    logic r_in_valid;
    logic r_in_level;

    // classifier state
    logic  r_stable;
    logic  r_hold_rep;
    t_time r_since_change;
    t_time r_since_step;

    // result stage
    logic               r_out_valid;
    bpc_pkg::t_out_item r_out;

    // next values
    logic               n_stable;
    logic               n_hold_rep;
    t_time              n_since_change;
    t_time              n_since_step;
    bpc_pkg::t_out_item n_out;

    logic                 w_out_free;
    logic                 w_move;
    logic                 w_level_pressed;
    logic                 w_accept;
    logic                 w_past_hold;
    t_time                w_sc_adv;
    t_time                w_ss_adv;
    t_time                w_sc_next;
    bpc_pkg::t_press_time w_press_sat;

    // handshake
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_move      = r_in_valid && w_out_free;
    assign i_in.ready  = !r_in_valid || w_out_free;
    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= bpc_pkg::DEBOUNCE_RST;
            r_hold_ms     <= bpc_pkg::HOLD_RST;
            r_step_ms     <= bpc_pkg::STEP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bpc_pkg::REG_DEBOUNCE: r_debounce_ms <= i_cfg.data;
                bpc_pkg::REG_HOLD:     r_hold_ms     <= i_cfg.data;
                bpc_pkg::REG_STEP:     r_step_ms     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // saturating tick advance of both elapsed counters
    assign w_sc_adv = (r_since_change == '1) ? r_since_change : r_since_change + 1'b1;
    assign w_ss_adv = (r_since_step == '1) ? r_since_step : r_since_step + 1'b1;

    // level change acceptance
    assign w_level_pressed = !r_in_level;
    assign w_accept        = (w_level_pressed != r_stable)
                             && (t_cmp'(w_sc_adv) > t_cmp'(r_debounce_ms));

    // change counter after acceptance
    assign w_sc_next = w_accept ? '0 : w_sc_adv;

    always_comb begin
        n_stable       = r_stable;
        n_hold_rep     = r_hold_rep;
        n_since_change = w_sc_adv;
        n_since_step   = w_ss_adv;
        n_out          = '0;
        n_out.event_res = bpc_pkg::EV_NONE;

        if (w_accept) begin
            n_stable       = w_level_pressed;
            n_since_change = '0;
            if (w_level_pressed) begin
                n_out.buzzer_on = 1'b1;
                n_hold_rep      = 1'b0;
            end else begin
                n_out.buzzer_off = 1'b1;
                if (!r_hold_rep) begin
                    n_out.event_res = bpc_pkg::EV_SHORT;
                end
            end
        end

        // long press, once per press
        if (n_stable && !n_hold_rep && w_past_hold) begin
            n_hold_rep      = 1'b1;
            n_out.event_res = bpc_pkg::EV_LONG;
        end

        // auto-repeat step
        if (n_stable && w_past_hold && (t_cmp'(w_ss_adv) > t_cmp'(r_step_ms))) begin
            n_since_step = '0;
            n_out.step   = 1'b1;
            n_out.chirp  = 1'b1;
        end

        n_out.pressed    = n_stable;
        n_out.press_time = n_stable ? w_press_sat : '0;
    end

    assign w_past_hold = t_cmp'(w_sc_next) > t_cmp'(r_hold_ms);

    // press duration clipped to the output width
    if (TIME_WIDTH > bpc_pkg::PRESS_W) begin : g_press_clip
        assign w_press_sat = (t_cmp'(w_sc_next) > t_cmp'({bpc_pkg::PRESS_W{1'b1}}))
                             ? '1 : w_sc_next[bpc_pkg::PRESS_W-1:0];
    end else begin : g_press_ext
        assign w_press_sat = bpc_pkg::t_press_time'(w_sc_next);
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_stable       <= 1'b0;
            r_hold_rep     <= 1'b0;
            r_since_change <= '0;
            r_since_step   <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_move) begin
                r_stable       <= n_stable;
                r_hold_rep     <= n_hold_rep;
                r_since_change <= n_since_change;
                r_since_step   <= n_since_step;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_level <= i_in.raw_level;
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

    // output drive
    assign o_out.valid      = r_out_valid;
    assign o_out.event_res  = r_out.event_res;
    assign o_out.pressed    = r_out.pressed;
    assign o_out.press_time = r_out.press_time;
    assign o_out.step       = r_out.step;
    assign o_out.buzzer_on  = r_out.buzzer_on;
    assign o_out.buzzer_off = r_out.buzzer_off;
    assign o_out.chirp      = r_out.chirp;

    // assertions
    `BPC_ASSERT_IMP(a_long_has_time, i_clk, i_rst_n,
        r_out_valid && (r_out.event_res == bpc_pkg::EV_LONG),
        r_out.pressed && (r_out.press_time != '0),
        "long press without a held press time")
    `BPC_ASSERT_IMP(a_press_restarts, i_clk, i_rst_n,
        $rose(r_stable), r_since_change == '0,
        "accepted press did not restart the change counter")
    `BPC_ASSERT_NEXT(a_step_restarts, i_clk, i_rst_n,
        w_move && n_out.step, r_since_step == '0,
        "step pulse did not restart the step counter")
    `BPC_ASSERT_IMP(a_step_chirp, i_clk, i_rst_n,
        r_out_valid && r_out.step, r_out.chirp && r_out.pressed,
        "step without chirp or while released")
    `BPC_ASSERT_NEXT(a_press_clears_hold, i_clk, i_rst_n,
        w_move && w_accept && w_level_pressed, !r_hold_rep || !r_stable,
        "long press flagged at the start of a press")

endmodule
`default_nettype wire
